// ===== rtl/erp_pkg.sv =====
// Shared types and constants of the e-paper refresh policy block.
// Used by the channel interfaces, the register file, the policy unit and the top level.
`timescale 1ns / 1ps
`default_nettype none

package erp_pkg;

	localparam int TIME_W  = 32;
	localparam int CNT_W   = 32;
	localparam int RUN_W   = 16;
	localparam int ACT_W   = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_POWEROFF_IDLE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIBERNATE_IDLE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_EVERY_PART = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_EVERY_MS   = 2'd3;

	localparam logic [TIME_W-1:0] POWEROFF_IDLE_RST   = 32'd5000;
	localparam logic [TIME_W-1:0] HIBERNATE_IDLE_RST  = 32'd60000;
	localparam logic [RUN_W-1:0]  FULL_EVERY_PART_RST = 16'd30;
	localparam logic [TIME_W-1:0] FULL_EVERY_MS_RST   = 32'd300000;

	typedef enum logic [ACT_W-1:0] {
		ACT_NONE    = 2'd0,
		ACT_PARTIAL = 2'd1,
		ACT_FULL    = 2'd2
	} action_t;

	typedef struct packed {
		logic [TIME_W-1:0] poweroff_idle_ms;
		logic [TIME_W-1:0] hibernate_idle_ms;
		logic [RUN_W-1:0]  full_every_partials;
		logic [TIME_W-1:0] full_every_ms;
	} cfg_t;

	typedef struct packed {
		logic [TIME_W-1:0] now_ms;
		logic              frame_changed;
	} tick_t;

	typedef struct packed {
		action_t           action;
		logic              power_off_cmd;
		logic              hibernate_cmd;
		logic [RUN_W-1:0]  shown_partial_count;
		logic [RUN_W-1:0]  partials_since_full;
		logic [CNT_W-1:0]  refresh_count;
		logic [CNT_W-1:0]  full_count;
		logic [CNT_W-1:0]  partial_total;
		logic [CNT_W-1:0]  skipped_count;
		logic              is_powered_off;
		logic              is_hibernating;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/erp_if.sv =====
// Valid/ready channel interfaces for the tick input and the decision result.
// Depends on erp_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface erp_tick_if
	import erp_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [TIME_W-1:0] now_ms;
	logic              frame_changed;

	modport source (output valid, output now_ms, output frame_changed, input ready);
	modport sink   (input valid, input now_ms, input frame_changed, output ready);
endinterface

interface erp_result_if
	import erp_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [ACT_W-1:0]  action;
	logic              power_off_cmd;
	logic              hibernate_cmd;
	logic [RUN_W-1:0]  shown_partial_count;
	logic [RUN_W-1:0]  partials_since_full;
	logic [CNT_W-1:0]  refresh_count;
	logic [CNT_W-1:0]  full_count;
	logic [CNT_W-1:0]  partial_total;
	logic [CNT_W-1:0]  skipped_count;
	logic              is_powered_off;
	logic              is_hibernating;

	modport source (
		output valid, output action, output power_off_cmd, output hibernate_cmd,
		output shown_partial_count, output partials_since_full, output refresh_count,
		output full_count, output partial_total, output skipped_count,
		output is_powered_off, output is_hibernating, input ready
	);
	modport sink (
		input valid, input action, input power_off_cmd, input hibernate_cmd,
		input shown_partial_count, input partials_since_full, input refresh_count,
		input full_count, input partial_total, input skipped_count,
		input is_powered_off, input is_hibernating, output ready
	);
endinterface

`default_nettype wire

// ===== rtl/epaper_refresh_policy_core.sv =====
// E-paper refresh policy block: top level with input and result registers.
// Depends on erp_pkg, erp_if, erp_cfg_regs and erp_policy.
//
// The tick channel carries one word per display tick: a millisecond timestamp
// and a frame-changed flag. The result channel returns one word per tick with
// the refresh action, the power-off and hibernate commands and the counters.
// A tick word is registered when accepted, decided from the input register
// and written to the result register when that one is empty or being read.
// The block takes one tick word every cycle while results are taken;
// the policy state is read and updated per word, which sets that rate.
// When the receiver stalls, the result register holds its word and the input
// register holds the next tick; tick ready drops only while both are full.
// Reset clears both registers and the policy state, so the first tick after
// reset gives a full refresh, and loads the default thresholds. Configuration
// writes take effect at the next clock edge and are meant for idle periods.
`timescale 1ns / 1ps
`default_nettype none

module epaper_refresh_policy_core
	import erp_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	erp_tick_if.sink                   tick,
	erp_result_if.source               result
);

	cfg_t    cfg;
	tick_t   tick_s1;
	logic    valid_s1;
	result_t res;
	result_t res_q;
	logic    res_valid_q;
	logic    advance;
	logic    accept;

	erp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	erp_policy u_policy (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.tick    (tick_s1),
		.advance (advance),
		.res     (res)
	);

	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign tick.ready = !valid_s1 || advance;
	assign accept     = tick.valid && tick.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tick_s1.now_ms        <= tick.now_ms;
			tick_s1.frame_changed <= tick.frame_changed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign result.valid               = res_valid_q;
	assign result.action              = res_q.action;
	assign result.power_off_cmd       = res_q.power_off_cmd;
	assign result.hibernate_cmd       = res_q.hibernate_cmd;
	assign result.shown_partial_count = res_q.shown_partial_count;
	assign result.partials_since_full = res_q.partials_since_full;
	assign result.refresh_count       = res_q.refresh_count;
	assign result.full_count          = res_q.full_count;
	assign result.partial_total       = res_q.partial_total;
	assign result.skipped_count       = res_q.skipped_count;
	assign result.is_powered_off      = res_q.is_powered_off;
	assign result.is_hibernating      = res_q.is_hibernating;

endmodule

`default_nettype wire

// ===== rtl/erp_cfg_regs.sv =====
// Configuration register file of the refresh policy: thresholds and periods.
// Depends on erp_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module erp_cfg_regs
	import erp_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.poweroff_idle_ms    <= POWEROFF_IDLE_RST;
			cfg_q.hibernate_idle_ms   <= HIBERNATE_IDLE_RST;
			cfg_q.full_every_partials <= FULL_EVERY_PART_RST;
			cfg_q.full_every_ms       <= FULL_EVERY_MS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POWEROFF_IDLE:   cfg_q.poweroff_idle_ms    <= cfg_wdata[TIME_W-1:0];
				REG_HIBERNATE_IDLE:  cfg_q.hibernate_idle_ms   <= cfg_wdata[TIME_W-1:0];
				REG_FULL_EVERY_PART: cfg_q.full_every_partials <= cfg_wdata[RUN_W-1:0];
				REG_FULL_EVERY_MS:   cfg_q.full_every_ms       <= cfg_wdata[TIME_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/erp_policy.sv =====
// Refresh decision and policy state: counters, timestamps and panel power flags.
// Depends on erp_pkg for cfg_t, tick_t, result_t and action_t.
`timescale 1ns / 1ps
`default_nettype none

module erp_policy
	import erp_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire tick_t tick,
	input  wire logic  advance,
	output result_t    res
);

	logic              first_q;
	logic [RUN_W-1:0]  run_q;
	logic [TIME_W-1:0] last_full_q;
	logic [TIME_W-1:0] last_change_q;
	logic              off_q;
	logic              asleep_q;
	logic [CNT_W-1:0]  refreshes_q;
	logic [CNT_W-1:0]  fulls_q;
	logic [CNT_W-1:0]  partials_q;
	logic [CNT_W-1:0]  skipped_q;

	logic              refresh;
	logic              full;
	logic [TIME_W-1:0] since_full;
	logic [TIME_W-1:0] idle;
	logic              pwr_cmd;
	logic              hib_cmd;
	logic [RUN_W-1:0]  run_d;
	logic [TIME_W-1:0] last_full_d;
	logic [TIME_W-1:0] last_change_d;
	logic              off_d;
	logic              asleep_d;
	logic [CNT_W-1:0]  refreshes_d;
	logic [CNT_W-1:0]  fulls_d;
	logic [CNT_W-1:0]  partials_d;
	logic [CNT_W-1:0]  skipped_d;

	always_comb begin
		refresh    = first_q || tick.frame_changed;
		since_full = tick.now_ms - last_full_q;
		idle       = tick.now_ms - last_change_q;
		full       = first_q || asleep_q || (run_q >= cfg.full_every_partials)
			|| (since_full >= cfg.full_every_ms);
		pwr_cmd    = !refresh && !off_q && (idle >= cfg.poweroff_idle_ms);
		hib_cmd    = !refresh && !asleep_q && (idle >= cfg.hibernate_idle_ms);

		run_d         = run_q;
		last_full_d   = last_full_q;
		last_change_d = last_change_q;
		off_d         = off_q || pwr_cmd;
		asleep_d      = asleep_q || hib_cmd;
		refreshes_d   = refreshes_q;
		fulls_d       = fulls_q;
		partials_d    = partials_q;
		skipped_d     = skipped_q;

		if (refresh) begin
			refreshes_d   = refreshes_q + 1'b1;
			off_d         = 1'b0;
			last_change_d = tick.now_ms;
			if (full) begin
				run_d       = '0;
				fulls_d     = fulls_q + 1'b1;
				last_full_d = tick.now_ms;
				asleep_d    = 1'b0;
			end else begin
				run_d      = run_q + 1'b1;
				partials_d = partials_q + 1'b1;
			end
		end else begin
			skipped_d = skipped_q + 1'b1;
		end

		if (!refresh) begin
			res.action = ACT_NONE;
		end else if (full) begin
			res.action = ACT_FULL;
		end else begin
			res.action = ACT_PARTIAL;
		end
		res.power_off_cmd       = pwr_cmd;
		res.hibernate_cmd       = hib_cmd;
		res.shown_partial_count = refresh ? run_q : '0;
		res.partials_since_full = run_d;
		res.refresh_count       = refreshes_d;
		res.full_count          = fulls_d;
		res.partial_total       = partials_d;
		res.skipped_count       = skipped_d;
		res.is_powered_off      = off_d;
		res.is_hibernating      = asleep_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q       <= 1'b1;
			run_q         <= '0;
			last_full_q   <= '0;
			last_change_q <= '0;
			off_q         <= 1'b0;
			asleep_q      <= 1'b0;
			refreshes_q   <= '0;
			fulls_q       <= '0;
			partials_q    <= '0;
			skipped_q     <= '0;
		end else if (advance) begin
			first_q       <= 1'b0;
			run_q         <= run_d;
			last_full_q   <= last_full_d;
			last_change_q <= last_change_d;
			off_q         <= off_d;
			asleep_q      <= asleep_d;
			refreshes_q   <= refreshes_d;
			fulls_q       <= fulls_d;
			partials_q    <= partials_d;
			skipped_q     <= skipped_d;
		end
	end

endmodule

`default_nettype wire
